### rtl/swrl_pkg.sv
// ----------------------------------------------------------------------------
// swrl_pkg
// shared constants and types of the sliding window rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

package swrl_pkg;

   // depth of the timestamp log
   localparam int MAX_ENTRIES = 16;
   localparam int PTR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

   // field widths
   localparam int TIME_W      = 32;
   localparam int MAXREQ_W    = 5;
   localparam int WINDOW_W    = 16;
   localparam int ENTRIES_W   = 5;

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_REQUESTS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

   // register reset values
   localparam logic [MAXREQ_W-1:0] MAX_REQUESTS_RST  = 5'd1;
   localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RST = 16'd1;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture request time
      logic pop;     // drop expired head entry
      logic finish;  // decide grant and load result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic expired;   // head entry present and out of window
      logic out_free;  // result register can take a beat
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/swrl_ram.sv
// ----------------------------------------------------------------------------
// swrl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                          wr_data,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/swrl_csr.sv
// ----------------------------------------------------------------------------
// swrl_csr
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [swrl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [swrl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [swrl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [swrl_pkg::MAXREQ_W-1:0]      max_requests,
   output logic [swrl_pkg::WINDOW_W-1:0]      window_length
);

   logic [swrl_pkg::MAXREQ_W-1:0] max_requests_ff;
   logic [swrl_pkg::MAXREQ_W-1:0] max_requests_in;
   logic [swrl_pkg::WINDOW_W-1:0] window_length_ff;
   logic [swrl_pkg::WINDOW_W-1:0] window_length_in;
   logic [swrl_pkg::CSR_IDX_W-1:0] reg_idx;
   logic                           wr_beat;

   assign reg_idx    = csr_paddr[swrl_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      max_requests_in  = max_requests_ff;
      window_length_in = window_length_ff;
      if (wr_beat) begin
         unique case (reg_idx)
            swrl_pkg::REG_MAX_REQUESTS: begin
               max_requests_in = csr_pwdata[swrl_pkg::MAXREQ_W-1:0];
            end
            swrl_pkg::REG_WINDOW_LENGTH: begin
               window_length_in = csr_pwdata[swrl_pkg::WINDOW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         swrl_pkg::REG_MAX_REQUESTS: begin
            csr_prdata = swrl_pkg::CSR_DATA_W'(max_requests_ff);
         end
         swrl_pkg::REG_WINDOW_LENGTH: begin
            csr_prdata = swrl_pkg::CSR_DATA_W'(window_length_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_requests_ff  <= swrl_pkg::MAX_REQUESTS_RST;
         window_length_ff <= swrl_pkg::WINDOW_LENGTH_RST;
      end else begin
         max_requests_ff  <= max_requests_in;
         window_length_ff <= window_length_in;
      end
   end

   assign max_requests  = max_requests_ff;
   assign window_length = window_length_ff;

endmodule

`default_nettype wire

### rtl/swrl_ctrl.sv
// ----------------------------------------------------------------------------
// swrl_ctrl
// sequencer: take a request, drop expired entries, then decide
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  swrl_pkg::dp_status_type  status,
   output swrl_pkg::ctrl_cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (status.expired) begin
               cmd.pop = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               // result register still held, wait
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/swrl_dp.sv
// ----------------------------------------------------------------------------
// swrl_dp
// timestamp log, pointers, occupancy, age compare and result register
// ----------------------------------------------------------------------------
`default_nettype none

module swrl_dp (
   input  wire                              clock,
   input  wire                              reset,
   input  swrl_pkg::ctrl_cmd_type           cmd,
   output swrl_pkg::dp_status_type          status,
   input  wire  [swrl_pkg::TIME_W-1:0]      req_request_time,
   input  wire  [swrl_pkg::MAXREQ_W-1:0]    max_requests,
   input  wire  [swrl_pkg::WINDOW_W-1:0]    window_length,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_granted,
   output logic [swrl_pkg::ENTRIES_W-1:0]   rsp_entries_in_window
);

   logic [swrl_pkg::TIME_W-1:0]   now_ff;
   logic [swrl_pkg::PTR_W-1:0]    head_ff;
   logic [swrl_pkg::PTR_W-1:0]    head_in;
   logic [swrl_pkg::PTR_W-1:0]    tail_ff;
   logic [swrl_pkg::PTR_W-1:0]    tail_in;
   logic [swrl_pkg::OCC_W-1:0]    occ_ff;
   logic [swrl_pkg::OCC_W-1:0]    occ_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_granted_ff;
   logic [swrl_pkg::ENTRIES_W-1:0] rsp_entries_ff;

   logic [swrl_pkg::PTR_W-1:0]    head_next;
   logic [swrl_pkg::PTR_W-1:0]    tail_next;
   logic [swrl_pkg::PTR_W-1:0]    rd_addr;
   logic [swrl_pkg::TIME_W-1:0]   head_time;
   logic [swrl_pkg::TIME_W-1:0]   age;
   logic [swrl_pkg::OCC_W-1:0]    limit;
   logic                          grant;
   logic                          wr_en;

   // pointer increments wrap at the log depth
   assign head_next = (32'(head_ff) == swrl_pkg::MAX_ENTRIES - 1) ?
                      '0 : swrl_pkg::PTR_W'(head_ff + 1'b1);
   assign tail_next = (32'(tail_ff) == swrl_pkg::MAX_ENTRIES - 1) ?
                      '0 : swrl_pkg::PTR_W'(tail_ff + 1'b1);

   // read ahead so the new head is ready the cycle after a pop
   assign rd_addr = cmd.pop ? head_next : head_ff;

   swrl_ram #(
      .WIDTH (swrl_pkg::TIME_W),
      .DEPTH (swrl_pkg::MAX_ENTRIES)
   ) u_log (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (head_time)
   );

   assign age   = now_ff - head_time;
   assign limit = (32'(max_requests) > swrl_pkg::MAX_ENTRIES) ?
                  swrl_pkg::OCC_W'(swrl_pkg::MAX_ENTRIES) :
                  swrl_pkg::OCC_W'(max_requests);
   assign grant = (occ_ff < limit);
   assign wr_en = cmd.finish & grant;

   assign status.expired  = (occ_ff != '0) &&
                            (age >= swrl_pkg::TIME_W'(window_length));
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (cmd.pop) begin
         head_in = head_next;
         occ_in  = swrl_pkg::OCC_W'(occ_ff - 1'b1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (grant) begin
            tail_in = tail_next;
            occ_in  = swrl_pkg::OCC_W'(occ_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff <= req_request_time;
      end
      if (cmd.finish) begin
         rsp_granted_ff <= grant;
         rsp_entries_ff <= swrl_pkg::ENTRIES_W'(occ_in);
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_granted           = rsp_granted_ff;
   assign rsp_entries_in_window = rsp_entries_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= swrl_pkg::MAX_ENTRIES)
      else $error("occupancy above log depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> (occ_ff != '0))
      else $error("pop from empty log");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result loaded over a held beat");

   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && grant) |=> (occ_ff == swrl_pkg::OCC_W'($past(occ_ff) + 1'b1)))
      else $error("grant did not add an entry");

   a_grant_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_granted_ff) |-> (rsp_entries_ff != '0))
      else $error("granted result with empty log");
`endif

endmodule

`default_nettype wire

### rtl/sliding_window_rate_limiter_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_unit
// sliding window log rate limiter with apb-style configuration
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per request, carrying its arrival time in seconds
//   rsp channel: one beat per request, granted flag and entries left in log
//   csr port: max_requests at byte 0, window_length at byte 4, write only
//     while the block is idle; pready is tied high
// timing
//   a request is taken only while no other request is in progress
//   an accepted beat is answered once every expired entry has been dropped
//     from the log head and the result register has taken the verdict
//   expired entries are dropped one at a time, since the timestamp ram hands
//     out one head entry per read; a new request is taken only after the
//     last one has been decided, and drops average at most one per request
// reset
//   synchronous; log empty, pointers zero, max_requests and window_length 1
// stall
//   the result sits in an output register; a new request is still taken
//   while it waits, and that request holds just before its result until
//   the waiting beat has been taken
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_limiter_unit (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [swrl_pkg::TIME_W-1:0]      req_request_time,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_granted,
   output logic [swrl_pkg::ENTRIES_W-1:0]   rsp_entries_in_window,
   // configuration port
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [swrl_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [swrl_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [swrl_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   // configuration values seen by the datapath
   logic [swrl_pkg::MAXREQ_W-1:0] max_requests;
   logic [swrl_pkg::WINDOW_W-1:0] window_length;

   // sequencer handshake with the datapath
   swrl_pkg::ctrl_cmd_type  cmd;
   swrl_pkg::dp_status_type status;

   swrl_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_requests  (max_requests),
      .window_length (window_length)
   );

   // idle -> eval on an accepted beat; eval drops expired heads one per
   // cycle, then decides once the result register is free
   swrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // log ram, head and tail pointers, occupancy, age compare, result register
   swrl_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_request_time      (req_request_time),
      .max_requests          (max_requests),
      .window_length         (window_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_granted           (rsp_granted),
      .rsp_entries_in_window (rsp_entries_in_window)
   );

endmodule

`default_nettype wire

### tb/sliding_window_rate_limiter_unit_tb.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter_unit_tb
// self-checking bench for the sliding window log rate limiter: a queue-fed
// driver offers request beats with random gaps, a scoreboard predicts the
// grant and log occupancy of every accepted beat, and a monitor compares each
// result beat against the oldest prediction while the receiver stalls at
// random; limits are reprogrammed over the csr port between traffic phases
// ----------------------------------------------------------------------------

module sliding_window_rate_limiter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // quiet cycles before the run is declared hung
   localparam int unsigned STALL_LIMIT   = 2000;
   // result beat count at which the receiver backs off hard, and for how long
   localparam int unsigned PRESSURE_AT   = 200;
   localparam int unsigned PRESSURE_HOLD = 300;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_BEATS   = 82;

   typedef struct packed {
      logic                           granted;
      logic [swrl_pkg::ENTRIES_W-1:0] entries;
   } verdict_type;

   // dut ports; the driven inputs are known from time zero
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [swrl_pkg::TIME_W-1:0]     req_request_time = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_granted;
   logic [swrl_pkg::ENTRIES_W-1:0]  rsp_entries_in_window;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [swrl_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [swrl_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [swrl_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // shadow copy of the limiter: config registers and timestamp log
   logic [swrl_pkg::MAXREQ_W-1:0]   cfg_max_requests  = swrl_pkg::MAX_REQUESTS_RST;
   logic [swrl_pkg::WINDOW_W-1:0]   cfg_window_length = swrl_pkg::WINDOW_LENGTH_RST;
   logic [swrl_pkg::TIME_W-1:0]     log_times [swrl_pkg::MAX_ENTRIES];
   logic [swrl_pkg::PTR_W-1:0]      log_head = '0;
   logic [swrl_pkg::PTR_W-1:0]      log_tail = '0;
   int unsigned                     log_count = 0;

   // request times waiting to be driven, verdicts waiting for their beat
   logic [swrl_pkg::TIME_W-1:0]     pending_requests [$];
   verdict_type                     awaiting_verdicts [$];

   // idling modes, changed per phase
   logic                  sender_idle_on = 1'b1;
   logic                  receiver_idle_on = 1'b1;

   int unsigned           mismatch_count = 0;
   int unsigned           requests_sent = 0;
   int unsigned           results_checked = 0;
   int unsigned           grants_seen = 0;
   int unsigned           settings_applied = 0;
   int unsigned           send_gap = 0;
   int unsigned           hold_left = 0;
   int unsigned           beats_taken = 0;
   logic                  pressure_done = 1'b0;
   int unsigned           quiet_cycles = 0;
   verdict_type           next_verdict;

   sliding_window_rate_limiter_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_request_time      (req_request_time),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_granted           (rsp_granted),
      .rsp_entries_in_window (rsp_entries_in_window),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(input logic enabled);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // expire old head entries, then grant if the log is below the limit
   function automatic verdict_type admit_request(input logic [swrl_pkg::TIME_W-1:0] stamp);
      int unsigned limit;
      verdict_type v;
      limit = (cfg_max_requests > swrl_pkg::MAX_ENTRIES) ?
              swrl_pkg::MAX_ENTRIES : int'(cfg_max_requests);
      // age wraps modulo 2^32, so a head entry stamped after the request time counts as expired
      while (log_count > 0 &&
             swrl_pkg::TIME_W'(stamp - log_times[log_head]) >= cfg_window_length) begin
         log_head  = log_head + 1'b1;
         log_count = log_count - 1;
      end
      v.granted = 1'b0;
      if (log_count < limit) begin
         log_times[log_tail] = stamp;
         log_tail  = log_tail + 1'b1;
         log_count = log_count + 1;
         v.granted = 1'b1;
      end
      v.entries = swrl_pkg::ENTRIES_W'(log_count);
      return v;
   endfunction

   // request driver: holds each beat until taken, then idles a random gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaiting_verdicts.push_back(admit_request(req_request_time));
            requests_sent <= requests_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_requests.size() != 0) begin
               req_valid        <= 1'b1;
               req_request_time <= pending_requests.pop_front();
               send_gap         <= pick_gap(sender_idle_on);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long back-off so the block fills up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) beats_taken <= beats_taken + 1;
         if (!pressure_done && beats_taken == PRESSURE_AT) begin
            rsp_stall     <= 1'b1;
            hold_left     <= PRESSURE_HOLD;
            pressure_done <= 1'b1;
         end else if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (receiver_idle_on && $urandom_range(0, 99) < 30) begin
            rsp_stall <= 1'b1;
            hold_left <= pick_gap(1'b1);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor: every beat against the oldest outstanding verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaiting_verdicts.size() == 0) begin
            $error("result beat with no request outstanding");
            mismatch_count++;
         end else begin
            next_verdict = awaiting_verdicts.pop_front();
            results_checked++;
            if (next_verdict.granted) grants_seen++;
            if (rsp_granted !== next_verdict.granted) begin
               $error("granted: expected %0d, actual %0d", next_verdict.granted, rsp_granted);
               mismatch_count++;
            end
            if (rsp_entries_in_window !== next_verdict.entries) begin
               $error("entries_in_window: expected %0d, actual %0d",
                      next_verdict.entries, rsp_entries_in_window);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog: any handshake or csr access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("sliding_window_rate_limiter_unit verification failed");
            $finish;
         end
      end
   end

   // wait until nothing is queued, in flight or owed
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || awaiting_verdicts.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // csr write (setup + access), then read back through the same select
   task automatic csr_write(input logic [swrl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [swrl_pkg::CSR_DATA_W-1:0] value);
      logic [swrl_pkg::CSR_DATA_W-1:0] readback;
      logic [swrl_pkg::CSR_DATA_W-1:0] want;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      // register takes the write at this edge; psel stays up for the read setup
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == swrl_pkg::REG_MAX_REQUESTS) begin
         cfg_max_requests = value[swrl_pkg::MAXREQ_W-1:0];
         want = swrl_pkg::CSR_DATA_W'(cfg_max_requests);
      end else begin
         cfg_window_length = value[swrl_pkg::WINDOW_W-1:0];
         want = swrl_pkg::CSR_DATA_W'(cfg_window_length);
      end
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== want) begin
         $error("csr readback at index %0d: expected %0d, actual %0d", idx, want, readback);
         mismatch_count++;
      end
   endtask

   // drain, then program both limits with junk in the unused upper bits
   task automatic program_limits(input logic [swrl_pkg::MAXREQ_W-1:0] max_req,
                                 input logic [swrl_pkg::WINDOW_W-1:0] window);
      logic [swrl_pkg::CSR_DATA_W-1:0] noisy;
      wait_for_drain();
      noisy = $urandom();
      noisy[swrl_pkg::MAXREQ_W-1:0] = max_req;
      csr_write(swrl_pkg::REG_MAX_REQUESTS, noisy);
      noisy = $urandom();
      noisy[swrl_pkg::WINDOW_W-1:0] = window;
      csr_write(swrl_pkg::REG_WINDOW_LENGTH, noisy);
      settings_applied++;
   endtask

   // random traffic: mostly forward time steps scaled so the log hovers near
   // its limit, a few long jumps, backward steps and arbitrary times
   task automatic queue_traffic(input int unsigned count);
      int unsigned                 spread;
      int unsigned                 r;
      logic [swrl_pkg::TIME_W-1:0] stamp;
      stamp  = $urandom();
      spread = (int'(cfg_window_length) / ((cfg_max_requests == 0) ? 1 : int'(cfg_max_requests)))
               * 2 + 1;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) stamp = stamp - $urandom_range(1, 100000);
         else if (r < 5) stamp = $urandom();
         else if (r < 10) stamp = stamp + $urandom_range(0, 3 * int'(cfg_window_length) + 2);
         else stamp = stamp + $urandom_range(0, spread);
         pending_requests.push_back(stamp);
      end
   endtask

   initial begin
      int unsigned                   p;
      logic [swrl_pkg::MAXREQ_W-1:0] max_pick;
      logic [swrl_pkg::WINDOW_W-1:0] window_pick;

      for (int i = 0; i < swrl_pkg::MAX_ENTRIES; i++) log_times[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset limits: one grant per one-second window, wrap at the top of time
      pending_requests.push_back(32'h0000_0000);
      pending_requests.push_back(32'h0000_0000);
      pending_requests.push_back(32'h0000_0001);
      pending_requests.push_back(32'hFFFF_FFFF);
      pending_requests.push_back(32'h0000_0000);
      pending_requests.push_back(32'hFFFF_FFFF);

      // zero limit rejects everything, widest window keeps the log
      program_limits(5'd0, 16'hFFFF);
      pending_requests.push_back(32'd100);
      pending_requests.push_back(32'd200);

      // zero window expires every entry, limit field at its top
      program_limits(5'd31, 16'd0);
      pending_requests.push_back(32'd300);
      pending_requests.push_back(32'd300);

      // limit above depth caps at a full log, then rejects
      program_limits(5'd17, 16'hFFFF);
      repeat (17) pending_requests.push_back(32'd1000);

      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 5)
            0: max_pick = $urandom_range(1, 16);
            1: max_pick = 5'd16;
            2: max_pick = $urandom_range(17, 31);
            3: max_pick = $urandom_range(0, 3);
            default: max_pick = $urandom_range(0, 31);
         endcase
         case (p % 4)
            0: window_pick = $urandom_range(1, 20);
            1: window_pick = 16'hFFFF;
            2: window_pick = 16'd0;
            default: window_pick = $urandom_range(0, 65535);
         endcase
         program_limits(max_pick, window_pick);
         // some phases run back to back on one side or the other
         sender_idle_on   <= (p % 3 != 0);
         receiver_idle_on <= (p % 3 != 1);
         queue_traffic(PHASE_BEATS);
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests (%0d granted) across %0d limit settings, %0d results checked",
               requests_sent, grants_seen, settings_applied, results_checked);
      if (mismatch_count == 0 && awaiting_verdicts.size() == 0) begin
         $display("sliding_window_rate_limiter_unit verification clean");
      end else begin
         $display("sliding_window_rate_limiter_unit verification failed");
      end
      $finish;
   end

endmodule
